FILE: rtl/lcw_pkg.sv
// Shared types, constants and the microcode table of the character LCD writer.
`timescale 1ns / 1ps
package lcw_pkg;

  localparam int SHADOW_DEPTH_DEF = 128;
  localparam int CHAR_W = 8;
  localparam int CFG_W = 6;
  localparam int UPC_W = 6;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_SETPOS = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_FLAGS  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_OFF    = 2'd2;
  localparam logic [1:0] ST_DROP   = 2'd3;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_DEGREE     = 8'hB0;
  localparam logic [7:0] CH_DEGREE_LCD = 8'hDF;
  localparam logic [7:0] LCD_SET_ADDR  = 8'h80;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_DISPLAY   = 8'h08;
  localparam logic [7:0] PIN_RS        = 8'h01;
  localparam logic [7:0] PIN_EN        = 8'h04;
  localparam logic [7:0] PIN_BL        = 8'h08;
  localparam logic [7:0] NIB_MASK      = 8'hF0;

  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h20, 8'h60};

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_PUT,
    C_DROP,
    C_ZERO,
    C_LF,
    C_CR,
    C_BADPOS,
    C_OFF,
    C_SAME,
    C_NO_REPOS,
    C_SETPOS,
    C_CLEAR
  } cond_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_CALC,
    A_LOAD_ADDR,
    A_LOAD_CHAR,
    A_NEWLINE,
    A_RETURN,
    A_SAME,
    A_ADVANCE,
    A_SETPOS,
    A_CLEAR,
    A_FLAGS
  } act_t;

  typedef enum logic [2:0] {
    E_NONE,
    E_NIB0,
    E_NIB1,
    E_NIB2,
    E_NIB3,
    E_STATUS
  } emit_t;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    act_t             act;
    emit_t            emit;
    logic [1:0]       status;
    logic             last;
    logic             fin;
    logic             set_drop;
  } ctrl_t;

  typedef struct packed {
    logic not_put;
    logic drop;
    logic zero;
    logic lf;
    logic cr;
    logic badpos;
    logic off;
    logic same;
    logic no_repos;
    logic is_setpos;
    logic is_clear;
  } conds_t;

  // entry points
  localparam logic [UPC_W-1:0] UA_DATA    = 6'd14;
  localparam logic [UPC_W-1:0] UA_OTHER   = 6'd20;
  localparam logic [UPC_W-1:0] UA_CLR     = 6'd24;
  localparam logic [UPC_W-1:0] UA_CMDOUT  = 6'd25;
  localparam logic [UPC_W-1:0] UA_DROPPED = 6'd32;
  localparam logic [UPC_W-1:0] UA_NUL     = 6'd33;
  localparam logic [UPC_W-1:0] UA_LF      = 6'd34;
  localparam logic [UPC_W-1:0] UA_CR      = 6'd35;
  localparam logic [UPC_W-1:0] UA_BADPOS  = 6'd36;
  localparam logic [UPC_W-1:0] UA_OFF     = 6'd37;
  localparam logic [UPC_W-1:0] UA_SAME    = 6'd38;
  localparam logic [UPC_W-1:0] UA_SETPOS  = 6'd39;

  function automatic ctrl_t cw(cond_t c, logic [UPC_W-1:0] t, act_t a, emit_t e,
                               logic [1:0] s, logic l, logic f, logic d);
    ctrl_t w;
    w.cond     = c;
    w.target   = t;
    w.act      = a;
    w.emit     = e;
    w.status   = s;
    w.last     = l;
    w.fin      = f;
    w.set_drop = d;
    return w;
  endfunction

  function automatic ctrl_t ucode(logic [UPC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      6'd0:  w = cw(C_NOT_PUT,  UA_OTHER,   A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd1:  w = cw(C_DROP,     UA_DROPPED, A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd2:  w = cw(C_ZERO,     UA_NUL,     A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd3:  w = cw(C_LF,       UA_LF,      A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd4:  w = cw(C_CR,       UA_CR,      A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd5:  w = cw(C_BADPOS,   UA_BADPOS,  A_CALC,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd6:  w = cw(C_OFF,      UA_OFF,     A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd7:  w = cw(C_SAME,     UA_SAME,    A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd8:  w = cw(C_NO_REPOS, UA_DATA,    A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd9:  w = cw(C_NONE,     '0,         A_LOAD_ADDR, E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd10: w = cw(C_NONE,     '0,         A_NONE,      E_NIB0, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd11: w = cw(C_NONE,     '0,         A_NONE,      E_NIB1, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd12: w = cw(C_NONE,     '0,         A_NONE,      E_NIB2, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd13: w = cw(C_NONE,     '0,         A_NONE,      E_NIB3, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd14: w = cw(C_NONE,     '0,         A_LOAD_CHAR, E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd15: w = cw(C_NONE,     '0,         A_NONE,      E_NIB0, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd16: w = cw(C_NONE,     '0,         A_NONE,      E_NIB1, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd17: w = cw(C_NONE,     '0,         A_NONE,      E_NIB2, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd18: w = cw(C_NONE,     '0,         A_ADVANCE,   E_NIB3, ST_OK, 1'b1, 1'b1, 1'b0);
      6'd20: w = cw(C_SETPOS,   UA_SETPOS,  A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd21: w = cw(C_CLEAR,    UA_CLR,     A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd22: w = cw(C_NONE,     '0,         A_FLAGS,     E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd23: w = cw(C_ALWAYS,   UA_CMDOUT,  A_NONE,      E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd24: w = cw(C_NONE,     '0,         A_CLEAR,     E_NONE, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd25: w = cw(C_NONE,     '0,         A_NONE,      E_NIB0, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd26: w = cw(C_NONE,     '0,         A_NONE,      E_NIB1, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd27: w = cw(C_NONE,     '0,         A_NONE,      E_NIB2, ST_OK, 1'b0, 1'b0, 1'b0);
      6'd28: w = cw(C_NONE,     '0,         A_NONE,      E_NIB3, ST_OK, 1'b1, 1'b1, 1'b0);
      6'd32: w = cw(C_NONE, '0, A_NONE,    E_STATUS, ST_DROP,   1'b1, 1'b1, 1'b0);
      6'd33: w = cw(C_NONE, '0, A_NONE,    E_STATUS, ST_OK,     1'b1, 1'b1, 1'b1);
      6'd34: w = cw(C_NONE, '0, A_NEWLINE, E_STATUS, ST_OK,     1'b1, 1'b1, 1'b0);
      6'd35: w = cw(C_NONE, '0, A_RETURN,  E_STATUS, ST_OK,     1'b1, 1'b1, 1'b0);
      6'd36: w = cw(C_NONE, '0, A_NONE,    E_STATUS, ST_BADPOS, 1'b1, 1'b1, 1'b1);
      6'd37: w = cw(C_NONE, '0, A_NONE,    E_STATUS, ST_OFF,    1'b1, 1'b1, 1'b1);
      6'd38: w = cw(C_NONE, '0, A_SAME,    E_STATUS, ST_OK,     1'b1, 1'b1, 1'b0);
      6'd39: w = cw(C_NONE, '0, A_SETPOS,  E_STATUS, ST_OK,     1'b1, 1'b1, 1'b0);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/lcw_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module lcw_ram #(
  parameter int WIDTH = lcw_pkg::CHAR_W,
  parameter int DEPTH = lcw_pkg::SHADOW_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lcw_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
`timescale 1ns / 1ps
module lcw_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lcw_pkg::conds_t conds,
  output lcw_pkg::ctrl_t  ctrl,
  output logic           busy,
  output logic           accept
);
  import lcw_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             busy_next;
  logic             take;

  assign accept = start && !busy;
  assign ctrl   = busy ? ucode(upc) : ctrl_t'('0);

  always_comb begin
    case (ctrl.cond)
      C_NONE:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NOT_PUT:  take = conds.not_put;
      C_DROP:     take = conds.drop;
      C_ZERO:     take = conds.zero;
      C_LF:       take = conds.lf;
      C_CR:       take = conds.cr;
      C_BADPOS:   take = conds.badpos;
      C_OFF:      take = conds.off;
      C_SAME:     take = conds.same;
      C_NO_REPOS: take = conds.no_repos;
      C_SETPOS:   take = conds.is_setpos;
      C_CLEAR:    take = conds.is_clear;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    upc_next  = upc;
    busy_next = busy;
    if (accept) begin
      upc_next  = '0;
      busy_next = 1'b1;
    end else if (busy) begin
      if (ctrl.fin) begin
        busy_next = 1'b0;
      end else if (take) begin
        upc_next = ctrl.target;
      end else begin
        upc_next = upc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= '0;
      busy <= 1'b0;
    end else begin
      upc  <= upc_next;
      busy <= busy_next;
    end
  end

endmodule

FILE: rtl/lcd_char_writer_with_shadow_cache.sv
// Top level: character LCD nibble writer with shadow screen copy.
//
//  channel  | direction | handshake             | beat carries
//  ---------+-----------+-----------------------+-----------------------------------------
//  command  | in        | start && !busy        | cmd, char_code, text_last, column, row,
//           |           |                       | display_on, cursor_on, blink_on
//  result   | out       | strobe, one cycle     | out_byte, byte_valid, status, last
//  config   | in        | cfg_we                | cfg_index, cfg_data
//
// One microcode step per clock, at most one result beat per step. A character with
// reposition takes the longest path from accept to its last beat, a status-only item
// the shortest; busy drops with the last beat. The shadow's valid bits clear at once
// on reset, so there is no clearing pass. The receiver cannot stall; beats leave on
// fixed cycles.
`timescale 1ns / 1ps
module lcd_char_writer_with_shadow_cache #(
  parameter int SHADOW_DEPTH = lcw_pkg::SHADOW_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd,
  input  logic [7:0]               char_code,
  input  logic                     text_last,
  input  logic [7:0]               column,
  input  logic [7:0]               row,
  input  logic                     display_on,
  input  logic                     cursor_on,
  input  logic                     blink_on,
  output logic                     strobe,
  output logic [7:0]               out_byte,
  output logic                     byte_valid,
  output logic [1:0]               status,
  output logic                     last,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [lcw_pkg::CFG_W-1:0] cfg_data
);
  import lcw_pkg::*;

  localparam int AW = $clog2(SHADOW_DEPTH);

  ctrl_t  ctrl;
  conds_t conds;
  logic   accept;

  cmd_t       item_cmd;
  logic [7:0] item_ch;
  logic       item_tlast;
  logic [7:0] item_col;
  logic [7:0] item_row;
  logic [2:0] item_flags;

  logic [5:0] columns;
  logic [2:0] rows;

  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       repos;
  logic [2:0] flags;
  logic       dropping;

  logic [7:0] addr;
  logic [7:0] send;
  logic       send_rs;
  logic [SHADOW_DEPTH-1:0] valid_bits;

  logic [7:0] ch_map;
  logic [2:0] nrows;
  logic [7:0] addr_calc;
  logic [7:0] rdata;
  logic [7:0] shadow_val;
  logic [7:0] nib;
  logic [7:0] beat_byte;
  logic       ram_we;

  lcw_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .conds  (conds),
    .ctrl   (ctrl),
    .busy   (busy),
    .accept (accept)
  );

  assign ram_we = (ctrl.act == A_LOAD_CHAR);

  lcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr[AW-1:0]),
    .wdata (ch_map),
    .raddr (addr[AW-1:0]),
    .rdata (rdata)
  );

  assign ch_map     = (item_ch == CH_DEGREE) ? CH_DEGREE_LCD : item_ch;
  assign nrows      = (rows > 3'd4) ? 3'd4 : rows;
  assign addr_calc  = ROW_BASE[cur_row[1:0]] + cur_col;
  assign shadow_val = valid_bits[addr[AW-1:0]] ? rdata : 8'h00;

  always_comb begin
    conds.not_put   = (item_cmd != CMD_PUT);
    conds.drop      = dropping;
    conds.zero      = (item_ch == CH_NUL);
    conds.lf        = (item_ch == CH_LF);
    conds.cr        = (item_ch == CH_CR);
    conds.badpos    = (cur_col >= {2'b00, columns}) || (cur_row >= {5'b00000, nrows});
    conds.off       = (addr >= 8'(SHADOW_DEPTH));
    conds.same      = (shadow_val == ch_map);
    conds.no_repos  = !repos;
    conds.is_setpos = (item_cmd == CMD_SETPOS);
    conds.is_clear  = (item_cmd == CMD_CLEAR);
  end

  always_comb begin
    case (ctrl.emit)
      E_NIB0, E_NIB1: nib = send & NIB_MASK;
      default:        nib = (send << 4) & NIB_MASK;
    endcase
    beat_byte = nib | PIN_BL | (send_rs ? PIN_RS : 8'h00);
    if (ctrl.emit == E_NIB0 || ctrl.emit == E_NIB2) begin
      beat_byte = beat_byte | PIN_EN;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd   <= cmd_t'(cmd);
      item_ch    <= char_code;
      item_tlast <= text_last;
      item_col   <= column;
      item_row   <= row;
      item_flags <= {display_on, cursor_on, blink_on};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 6'd16;
      rows    <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMNS: columns <= cfg_data;
        REG_ROWS:    rows    <= cfg_data[2:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= '0;
      cur_row  <= '0;
      repos    <= 1'b0;
      flags    <= '0;
      dropping <= 1'b0;
    end else begin
      case (ctrl.act)
        A_LOAD_ADDR: repos <= 1'b0;
        A_NEWLINE: begin
          cur_row <= cur_row + 8'd1;
          cur_col <= '0;
          repos   <= 1'b1;
        end
        A_RETURN: begin
          cur_col <= '0;
          repos   <= 1'b1;
        end
        A_SAME: begin
          cur_col <= cur_col + 8'd1;
          repos   <= 1'b1;
        end
        A_ADVANCE: cur_col <= cur_col + 8'd1;
        A_SETPOS: begin
          if (cur_col != item_col || cur_row != item_row) begin
            cur_col <= item_col;
            cur_row <= item_row;
            repos   <= 1'b1;
          end
        end
        A_CLEAR: begin
          cur_col <= '0;
          cur_row <= '0;
          repos   <= 1'b0;
        end
        A_FLAGS: flags <= item_flags;
        default: ;
      endcase
      if (ctrl.fin) begin
        if (item_cmd == CMD_PUT && !item_tlast) begin
          dropping <= dropping | ctrl.set_drop;
        end else begin
          dropping <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (ctrl.act == A_CLEAR) begin
      valid_bits <= '0;
    end else if (ram_we) begin
      valid_bits[addr[AW-1:0]] <= 1'b1;
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    case (ctrl.act)
      A_CALC: addr <= addr_calc;
      A_LOAD_ADDR: begin
        send    <= LCD_SET_ADDR | addr;
        send_rs <= 1'b0;
      end
      A_LOAD_CHAR: begin
        send    <= ch_map;
        send_rs <= 1'b1;
      end
      A_CLEAR: begin
        send    <= LCD_CLEAR;
        send_rs <= 1'b0;
      end
      A_FLAGS: begin
        send    <= LCD_DISPLAY | {5'b00000, item_flags};
        send_rs <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (ctrl.emit != E_NONE);
    end
  end

  always_ff @(posedge clk) begin
    last <= ctrl.last;
    if (ctrl.emit == E_STATUS) begin
      out_byte   <= 8'h00;
      byte_valid <= 1'b0;
      status     <= ctrl.status;
    end else begin
      out_byte   <= beat_byte;
      byte_valid <= 1'b1;
      status     <= ST_OK;
    end
  end

endmodule

FILE: rtl/lcw_checker.sv
// Port-level checks on the LCD writer, bound to its top level.
`timescale 1ns / 1ps
module lcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] status,
  input logic       last
);
  import lcw_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_beat_inside_item: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final beat outside an item");

  a_done_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> strobe && last)
    else $error("item ended without its final beat");

  a_byte_ok_status: assert property (@(posedge clk) disable iff (rst)
    strobe && byte_valid |-> status == ST_OK)
    else $error("byte beat with nonzero status");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    strobe && !byte_valid |-> last && out_byte == 8'h00)
    else $error("status-only beat not alone or carries a byte");

endmodule

bind lcd_char_writer_with_shadow_cache lcw_checker u_lcw_checker (.*);

FILE: tb/lcd_char_writer_with_shadow_cache_tb.sv
// Self-checking testbench for the character LCD writer with shadow screen copy.
`timescale 1ns / 1ps
module lcd_char_writer_with_shadow_cache_tb;
  import lcw_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last;
  } lcd_beat_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       cmd;
  logic [7:0]       char_code;
  logic             text_last;
  logic [7:0]       column;
  logic [7:0]       row;
  logic             display_on;
  logic             cursor_on;
  logic             blink_on;
  logic             strobe;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic [1:0]       status;
  logic             last;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lcd_char_writer_with_shadow_cache u_top (.*);

  always #5 clk = ~clk;

  // shadow-screen model state
  logic [7:0] shadow_copy [SHADOW_DEPTH_DEF];
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       repos_pending;
  logic       dropping;
  logic [2:0] disp_flags;
  logic [5:0] columns_reg;
  logic [2:0] rows_reg;

  lcd_beat_t lcd_beats_due[$];
  int        send_idle_pct;
  int        items_sent;
  int        beats_seen;
  int        err_count;
  int        status_seen [4];

  function automatic void reset_shadow_model();
    foreach (shadow_copy[i]) shadow_copy[i] = 8'h00;
    cur_col       = 8'h00;
    cur_row       = 8'h00;
    repos_pending = 1'b0;
    dropping      = 1'b0;
    disp_flags    = 3'b000;
    columns_reg   = 6'd16;
    rows_reg      = 3'd2;
  endfunction

  function automatic void queue_beat(logic [7:0] b, logic v, logic [1:0] s);
    lcd_beat_t t;
    t.out_byte   = b;
    t.byte_valid = v;
    t.status     = s;
    t.last       = 1'b0;
    lcd_beats_due.push_back(t);
  endfunction

  // one LCD byte = four expander beats: hi+E, hi, lo+E, lo
  function automatic void queue_lcd_byte(logic [7:0] d, logic [7:0] rs);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = d & NIB_MASK;
    lo = {d[3:0], 4'h0};
    queue_beat(rs | PIN_BL | PIN_EN | hi, 1'b1, ST_OK);
    queue_beat(rs | PIN_BL | hi, 1'b1, ST_OK);
    queue_beat(rs | PIN_BL | PIN_EN | lo, 1'b1, ST_OK);
    queue_beat(rs | PIN_BL | lo, 1'b1, ST_OK);
  endfunction

  function automatic void shadow_lcd_step(cmd_t op, logic [7:0] ch, logic tl,
                                          logic [7:0] col, logic [7:0] rw,
                                          logic [2:0] fl);
    int         first;
    int         nrows;
    int         at;
    logic [7:0] c;
    first = lcd_beats_due.size();
    c     = ch;
    nrows = (rows_reg > 3'd4) ? 4 : int'(rows_reg);
    if (op == CMD_PUT) begin
      if (dropping) begin
        queue_beat(8'h00, 1'b0, ST_DROP);
      end else if (c == CH_NUL) begin
        queue_beat(8'h00, 1'b0, ST_OK);
        dropping = 1'b1;
      end else if (c == CH_LF) begin
        cur_row       = cur_row + 8'd1;
        cur_col       = 8'h00;
        repos_pending = 1'b1;
      end else if (c == CH_CR) begin
        cur_col       = 8'h00;
        repos_pending = 1'b1;
      end else begin
        if (c == CH_DEGREE) c = CH_DEGREE_LCD;
        at = int'(ROW_BASE[cur_row[1:0]]) + int'(cur_col);
        if (int'(cur_col) >= int'(columns_reg) || int'(cur_row) >= nrows) begin
          queue_beat(8'h00, 1'b0, ST_BADPOS);
          dropping = 1'b1;
        end else if (at >= SHADOW_DEPTH_DEF) begin
          queue_beat(8'h00, 1'b0, ST_OFF);
          dropping = 1'b1;
        end else begin
          if (shadow_copy[at] != c) begin
            if (repos_pending) begin
              queue_lcd_byte(LCD_SET_ADDR | 8'(at), 8'h00);
              repos_pending = 1'b0;
            end
            shadow_copy[at] = c;
            queue_lcd_byte(c, PIN_RS);
          end else begin
            repos_pending = 1'b1;
          end
          cur_col = cur_col + 8'd1;
        end
      end
      if (tl) dropping = 1'b0;
    end else begin
      dropping = 1'b0;
      if (op == CMD_SETPOS) begin
        if (cur_col != col || cur_row != rw) begin
          cur_col       = col;
          cur_row       = rw;
          repos_pending = 1'b1;
        end
      end else if (op == CMD_CLEAR) begin
        cur_col       = 8'h00;
        cur_row       = 8'h00;
        repos_pending = 1'b0;
        foreach (shadow_copy[i]) shadow_copy[i] = 8'h00;
        queue_lcd_byte(LCD_CLEAR, 8'h00);
      end else begin
        disp_flags = fl;
        queue_lcd_byte(LCD_DISPLAY | {5'b0, fl}, 8'h00);
      end
    end
    if (lcd_beats_due.size() == first) queue_beat(8'h00, 1'b0, ST_OK);
    lcd_beats_due[lcd_beats_due.size() - 1].last = 1'b1;
  endfunction

  task automatic send_item(cmd_t op, logic [7:0] ch, logic tl, logic [7:0] col,
                           logic [7:0] rw, logic [2:0] fl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= op;
    char_code  <= ch;
    text_last  <= tl;
    column     <= col;
    row        <= rw;
    display_on <= fl[2];
    cursor_on  <= fl[1];
    blink_on   <= fl[0];
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow_lcd_step(op, ch, tl, col, rw, fl);
    items_sent++;
  endtask

  task automatic put_text_char(logic [7:0] ch, logic tl);
    send_item(CMD_PUT, ch, tl, 8'($urandom), 8'($urandom), 3'($urandom));
  endtask

  task automatic set_position(logic [7:0] col, logic [7:0] rw);
    send_item(CMD_SETPOS, 8'($urandom), 1'($urandom), col, rw, 3'($urandom));
  endtask

  task automatic clear_screen();
    send_item(CMD_CLEAR, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
              3'($urandom));
  endtask

  task automatic set_flags(logic [2:0] fl);
    send_item(CMD_FLAGS, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), fl);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (lcd_beats_due.size() != 0 || busy);
  endtask

  // rows write carries junk in the unused upper bits
  task automatic configure(logic [5:0] cols, logic [2:0] rws);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    columns_reg = cols;
    cfg_index <= REG_ROWS;
    cfg_data  <= {3'($urandom), rws};
    @(posedge clk);
    rows_reg = rws;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] text_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 58) return 8'h41 + 8'($urandom_range(0, 3));
    if (p < 66) return CH_LF;
    if (p < 72) return CH_CR;
    if (p < 78) return CH_DEGREE;
    if (p < 80) return CH_DEGREE_LCD;
    if (p < 83) return CH_NUL;
    return 8'($urandom);
  endfunction

  task automatic test_display_commands();
    set_flags(3'b111);
    set_flags(3'b000);
    clear_screen();
  endtask

  task automatic test_text_paths();
    put_text_char("H", 1'b0);
    put_text_char(CH_DEGREE, 1'b1);
    set_position(8'd0, 8'd0);
    put_text_char("H", 1'b0);
    put_text_char(8'hFF, 1'b1);
    put_text_char(CH_LF, 1'b0);
    put_text_char("x", 1'b0);
    put_text_char(CH_CR, 1'b0);
    put_text_char("y", 1'b1);
  endtask

  task automatic test_text_drop();
    set_position(8'd255, 8'd255);
    put_text_char("z", 1'b0);
    put_text_char("q", 1'b0);
    put_text_char("r", 1'b1);
    put_text_char(CH_NUL, 1'b0);
    put_text_char("a", 1'b1);
    set_position(8'd15, 8'd1);
    put_text_char("e", 1'b0);
    put_text_char("f", 1'b1);
    put_text_char(CH_NUL, 1'b0);
    set_flags(3'b101);
    put_text_char("b", 1'b1);
  endtask

  task automatic test_geometry();
    configure(6'd1, 3'd1);
    set_position(8'd0, 8'd0);
    put_text_char("k", 1'b0);
    put_text_char("l", 1'b1);
    set_position(8'd0, 8'd1);
    put_text_char("m", 1'b1);
    configure(6'd63, 3'd7);
    set_position(8'd40, 8'd3);
    put_text_char("o", 1'b1);
    set_position(8'd62, 8'd2);
    put_text_char("p", 1'b1);
    set_position(8'd31, 8'd3);
    put_text_char("s", 1'b1);
    set_position(8'd0, 8'd4);
    put_text_char("n", 1'b1);
  endtask

  task automatic random_traffic(int n_items, int idle_pct, logic [5:0] cols,
                                logic [2:0] rws);
    int stop_at;
    int pick;
    int len;
    int nrows;
    configure(cols, rws);
    send_idle_pct = idle_pct;
    nrows   = (rws > 3'd4) ? 4 : int'(rws);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        clear_screen();
      end else if (pick < 10) begin
        set_flags(3'($urandom));
      end else if (pick < 15) begin
        set_position(8'($urandom), 8'($urandom));
        put_text_char(text_char(), 1'($urandom));
      end else if (pick < 20) begin
        put_text_char(8'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(0, 3) != 0)
          set_position(8'($urandom_range(0, cols - 1)), 8'($urandom_range(0, nrows - 1)));
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          put_text_char(text_char(), (i == len - 1) ? ($urandom_range(0, 9) != 0) : 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    lcd_beat_t want;
    if (!rst && strobe) begin
      beats_seen++;
      if (!byte_valid) status_seen[status]++;
      if (lcd_beats_due.size() == 0) begin
        $error("unexpected beat: out_byte %h byte_valid %b status %0d last %b",
               out_byte, byte_valid, status, last);
        err_count++;
      end else begin
        want = lcd_beats_due.pop_front();
        if (out_byte !== want.out_byte) begin
          $error("out_byte expected %h actual %h", want.out_byte, out_byte);
          err_count++;
        end
        if (byte_valid !== want.byte_valid) begin
          $error("byte_valid expected %b actual %b", want.byte_valid, byte_valid);
          err_count++;
        end
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last expected %b actual %b", want.last, last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    cmd        <= CMD_PUT;
    char_code  <= 8'h00;
    text_last  <= 1'b0;
    column     <= 8'h00;
    row        <= 8'h00;
    display_on <= 1'b0;
    cursor_on  <= 1'b0;
    blink_on   <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_COLUMNS;
    cfg_data   <= '0;
    reset_shadow_model();
    items_sent    = 0;
    beats_seen    = 0;
    err_count     = 0;
    send_idle_pct = 34;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_display_commands();
    test_text_paths();
    test_text_drop();
    test_geometry();
    random_traffic(160, 34, 6'd16, 3'd2);
    random_traffic(160, 57, 6'd32, 3'd4);
    random_traffic(160, 0, 6'd5, 3'd6);
    drain_results();
    repeat (40) @(posedge clk);

    $display("%0d commands sent, %0d beats checked; status-only: ok %0d, bad pos %0d, %s",
             items_sent, beats_seen, status_seen[ST_OK], status_seen[ST_BADPOS],
             $sformatf("off shadow %0d, dropped %0d", status_seen[ST_OFF],
                       status_seen[ST_DROP]));
    $display("geometries 1x1 to 63x7, sender gaps at 34%%, 57%% and none");
    if (err_count == 0 && lcd_beats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
